### rtl/varint_zigzag_codec_assert.svh
// Assertion helpers, sampled on the rising clock edge, quiet while reset is high.
`ifndef VARINT_ZIGZAG_CODEC_ASSERT_SVH
`define VARINT_ZIGZAG_CODEC_ASSERT_SVH

// Same-cycle implication.
`define VZC_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define VZC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/vzc_pkg.sv
`default_nettype none

package vzc_pkg;

   localparam int WORD_BITS  = 64;
   localparam int HALF_BITS  = 32;
   localparam int GROUP_BITS = 7;
   localparam int BYTE_BITS  = 8;
   localparam int CNT_BITS   = 4;

   localparam logic [BYTE_BITS-1:0]  CONT_BIT   = 8'h80;
   localparam logic [GROUP_BITS-1:0] GROUP_MASK = 7'h7F;

   // group limits per value and the most continued bytes per value on encode
   localparam logic [CNT_BITS:0]   MAX_GROUPS_WIDE   = 5'd10;
   localparam logic [CNT_BITS:0]   MAX_GROUPS_NARROW = 5'd5;
   localparam logic [CNT_BITS-1:0] MAX_GROUPS_ALL    = 4'd10;
   localparam logic [CNT_BITS-1:0] MAX_CONT_BYTES    = 4'd9;

   typedef enum logic {
      KIND_ENCODE = 1'b0,
      KIND_DECODE = 1'b1
   } kind_type;

   typedef enum logic {
      REG_WIDE_MODE   = 1'b0,
      REG_SIGNED_MODE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic wide;
      logic zigzag;
   } mode_type;

   // queue entry: word to encode, or finished decoded value
   typedef struct packed {
      kind_type             kind;
      logic [WORD_BITS-1:0] word;
   } entry_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   function automatic logic [WORD_BITS-1:0] word_mask(input logic wide);
      word_mask = wide ? {WORD_BITS{1'b1}} : {{HALF_BITS{1'b0}}, {HALF_BITS{1'b1}}};
   endfunction

endpackage

`default_nettype wire

### rtl/vzc_front.sv
`default_nettype none

module vzc_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire vzc_pkg::mode_type       mode,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire vzc_pkg::kind_type       kind,
   input  wire [vzc_pkg::WORD_BITS-1:0] value,
   input  wire [vzc_pkg::BYTE_BITS-1:0] byte_in,
   input  wire vzc_pkg::queue_status_type q_status,
   output logic                         push,
   output vzc_pkg::entry_type           push_entry
);

   logic [vzc_pkg::WORD_BITS-1:0] acc_ff, acc_in;
   logic [vzc_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;

   logic [vzc_pkg::WORD_BITS-1:0] mask;
   logic [vzc_pkg::WORD_BITS-1:0] enc_word;
   logic                          enc_top;
   logic [6:0]                    sh_full;
   logic [5:0]                    sh_amt;
   logic [vzc_pkg::WORD_BITS-1:0] grp;
   logic [vzc_pkg::WORD_BITS-1:0] acc_new;
   logic [vzc_pkg::CNT_BITS:0]    cnt_next;
   logic [vzc_pkg::CNT_BITS:0]    limit;
   logic                          dec_done;
   logic [vzc_pkg::WORD_BITS-1:0] dec_word;
   logic                          accept;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      mask = vzc_pkg::word_mask(mode.wide);

      // encode side: mask to word width, then zigzag if signed mode is on
      enc_word = value & mask;
      enc_top  = mode.wide ? enc_word[vzc_pkg::WORD_BITS-1] : enc_word[vzc_pkg::HALF_BITS-1];
      if (mode.zigzag) begin
         enc_word = ((enc_word << 1) ^ {vzc_pkg::WORD_BITS{enc_top}}) & mask;
      end

      // decode side: drop groups past the tenth, OR the new group in place
      sh_full = {3'b000, cnt_ff} * 7'd7;
      sh_amt  = sh_full[5:0];
      grp     = {{(vzc_pkg::WORD_BITS-vzc_pkg::GROUP_BITS){1'b0}},
                 byte_in[vzc_pkg::GROUP_BITS-1:0] & vzc_pkg::GROUP_MASK} << sh_amt;
      if (cnt_ff < vzc_pkg::MAX_GROUPS_ALL) begin
         acc_new = (acc_ff | grp) & mask;
      end else begin
         acc_new = acc_ff & mask;
      end
      cnt_next = {1'b0, cnt_ff} + 5'd1;
      limit    = mode.wide ? vzc_pkg::MAX_GROUPS_WIDE : vzc_pkg::MAX_GROUPS_NARROW;
      dec_done = ((byte_in & vzc_pkg::CONT_BIT) == '0) || (cnt_next >= limit);
      dec_word = acc_new;
      if (mode.zigzag) begin
         dec_word = ((acc_new >> 1) ^ {vzc_pkg::WORD_BITS{acc_new[0]}}) & mask;
      end

      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (accept && kind == vzc_pkg::KIND_DECODE) begin
         if (dec_done) begin
            acc_in = '0;
            cnt_in = '0;
         end else begin
            acc_in = acc_new;
            cnt_in = cnt_next[vzc_pkg::CNT_BITS-1:0];
         end
      end

      push            = accept && (kind == vzc_pkg::KIND_ENCODE || dec_done);
      push_entry.kind = kind;
      push_entry.word = (kind == vzc_pkg::KIND_ENCODE) ? enc_word : dec_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### rtl/vzc_fifo.sv
`default_nettype none

module vzc_fifo (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           push,
   input  wire vzc_pkg::entry_type       push_entry,
   input  wire                           pop,
   output vzc_pkg::entry_type            head,
   output vzc_pkg::queue_status_type     status
);

   localparam int DEPTH = 2;

   vzc_pkg::entry_type mem_ff [DEPTH];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == 2'(DEPTH));
      status.valid = (count_ff != 2'd0);
      head         = mem_ff[rd_ptr_ff];
      wr_ptr_in    = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/vzc_back.sv
`default_nettype none

module vzc_back (
   input  wire                              clock,
   input  wire                              reset,
   input  wire vzc_pkg::queue_status_type   q_status,
   input  wire vzc_pkg::entry_type          head,
   output logic                             pop,
   output logic                             out_valid,
   input  wire                              out_ready,
   output vzc_pkg::kind_type                out_kind,
   output logic [vzc_pkg::BYTE_BITS-1:0]    out_byte,
   output logic                             out_last,
   output logic [vzc_pkg::WORD_BITS-1:0]    out_value
);

   logic                          valid_ff;
   vzc_pkg::kind_type             kind_ff, kind_in;
   logic [vzc_pkg::BYTE_BITS-1:0] byte_ff, byte_in;
   logic                          last_ff, last_in;
   logic [vzc_pkg::WORD_BITS-1:0] value_ff, value_in;
   logic [vzc_pkg::WORD_BITS-1:0] cur_ff, cur_in;
   logic                          started_ff, started_in;
   logic [vzc_pkg::CNT_BITS-1:0]  n_ff, n_in;

   logic                          slot_free;
   logic                          emit;
   logic                          more;
   logic [vzc_pkg::WORD_BITS-1:0] src;

   always_comb begin
      slot_free = !valid_ff || out_ready;
      emit      = q_status.valid && slot_free;
      src       = started_ff ? cur_ff : head.word;
      more      = (head.kind == vzc_pkg::KIND_ENCODE)
                  && (src[vzc_pkg::WORD_BITS-1:vzc_pkg::GROUP_BITS] != '0)
                  && (n_ff < vzc_pkg::MAX_CONT_BYTES);
      pop       = emit && !more;

      kind_in    = kind_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      value_in   = value_ff;
      cur_in     = cur_ff;
      started_in = started_ff;
      n_in       = n_ff;
      if (emit) begin
         kind_in = head.kind;
         unique case (head.kind)
            vzc_pkg::KIND_ENCODE: begin
               byte_in  = more ? ({1'b0, src[vzc_pkg::GROUP_BITS-1:0]} | vzc_pkg::CONT_BIT)
                               : src[vzc_pkg::BYTE_BITS-1:0];
               last_in  = !more;
               value_in = '0;
            end
            vzc_pkg::KIND_DECODE: begin
               byte_in  = '0;
               last_in  = 1'b1;
               value_in = head.word;
            end
         endcase
         if (more) begin
            cur_in     = src >> vzc_pkg::GROUP_BITS;
            started_in = 1'b1;
            n_in       = n_ff + 4'd1;
         end else begin
            started_in = 1'b0;
            n_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      value_ff <= value_in;
      cur_ff   <= cur_in;
      if (reset) begin
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
         n_ff       <= '0;
      end else begin
         if (slot_free) begin
            valid_ff <= emit;
         end
         started_ff <= started_in;
         n_ff       <= n_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_value = value_ff;

endmodule

`default_nettype wire

### rtl/varint_zigzag_codec.sv
// rsp_tvalid for an input transfer that causes a result is set from the queue entry that
// the transfer writes, through the output register; the result may wait in the queue.
// One input transfer per cycle is taken while the 2-entry queue has room; the output
// stage emits one result per cycle while rsp_tready is high, and an encode of k bytes
// (1 to 10) gives k results, and a decode byte gives 0 or 1 result.
// Reset: synchronous, clears queue, output stage and decode state; wide_mode = 1,
// signed_mode = 0. Ready to take input as soon as reset is released.
`default_nettype none

`include "varint_zigzag_codec_assert.svh"

module varint_zigzag_codec (
   input  wire         clock,
   input  wire         reset,
   // slave stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [71:0] req_tdata,   // [63:0] value, [71:64] byte_in
   input  wire         req_tuser,   // [0] kind
   // master stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // [7:0] out_byte, [71:8] decoded_value
   output logic        rsp_tuser,   // [0] out_kind
   output logic        rsp_tlast,
   // register port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                          wide_ff, zigzag_ff;
   logic                          csr_write;
   vzc_pkg::reg_index_type        csr_index;
   vzc_pkg::mode_type             mode;
   vzc_pkg::queue_status_type     q_status;
   vzc_pkg::entry_type            push_entry;
   vzc_pkg::entry_type            head;
   logic                          push;
   logic                          pop;
   vzc_pkg::kind_type             out_kind;
   logic [vzc_pkg::BYTE_BITS-1:0] out_byte;
   logic [vzc_pkg::WORD_BITS-1:0] out_value;
   logic                          in_encode;
   logic                          out_decode;
   logic                          out_cont;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = vzc_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      unique case (csr_index)
         vzc_pkg::REG_WIDE_MODE:   csr_prdata = {31'd0, wide_ff};
         vzc_pkg::REG_SIGNED_MODE: csr_prdata = {31'd0, zigzag_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff   <= 1'b1;
         zigzag_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            vzc_pkg::REG_WIDE_MODE:   wide_ff   <= csr_pwdata[0];
            vzc_pkg::REG_SIGNED_MODE: zigzag_ff <= csr_pwdata[0];
         endcase
      end
   end

   assign mode.wide   = wide_ff;
   assign mode.zigzag = zigzag_ff;

   vzc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .kind       (vzc_pkg::kind_type'(req_tuser)),
      .value      (req_tdata[63:0]),
      .byte_in    (req_tdata[71:64]),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   vzc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   vzc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (out_kind),
      .out_byte  (out_byte),
      .out_last  (rsp_tlast),
      .out_value (out_value)
   );

   assign rsp_tuser = out_kind;
   assign rsp_tdata = {out_value, out_byte};

   assign in_encode  = req_tvalid && req_tready
                       && (vzc_pkg::kind_type'(req_tuser) == vzc_pkg::KIND_ENCODE);
   assign out_decode = rsp_tvalid && (out_kind == vzc_pkg::KIND_DECODE);
   assign out_cont   = rsp_tvalid && (out_kind == vzc_pkg::KIND_ENCODE) && !rsp_tlast;

   `VZC_ASSERT_IMPLIES(a_full_has_head, q_status.full, q_status.valid, "queue full but empty")
   `VZC_ASSERT_NEXT(a_encode_queued, in_encode, q_status.valid, "encode not queued")
   `VZC_ASSERT_IMPLIES(a_decode_shape, out_decode, rsp_tlast && out_byte == '0, "bad decode")
   `VZC_ASSERT_IMPLIES(a_cont_flag, out_cont, rsp_tdata[7], "continued byte lacks flag")

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int DRAIN_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      vzc_pkg::kind_type out_kind;
      logic [7:0]        out_byte;
      logic              last;
      logic [63:0]       value;
   } codec_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // [63:0] value, [71:64] byte_in
   logic        req_tuser = 1'b0; // [0] kind

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // [7:0] out_byte, [71:8] decoded_value
   logic        rsp_tuser;        // [0] out_kind
   logic        rsp_tlast;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor copy of the block's registers and decode state
   logic        mode_wide = 1'b1;
   logic        mode_zigzag = 1'b0;
   logic [63:0] decode_acc = '0;
   int unsigned decode_groups = 0;

   codec_result_type pending_results[$];
   codec_result_type oldest;

   int unsigned mismatch_count = 0;
   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned ready_phase_left = 0;
   int unsigned idle_cycles = 0;

   varint_zigzag_codec dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // append one expected result at the tail
   task automatic expect_result(input codec_result_type r);
      pending_results.insert(pending_results.size(), r);
   endtask

   // work out the results one accepted item causes
   task automatic predict_codec(input vzc_pkg::kind_type kind, input logic [63:0] word,
                                input logic [7:0] data_byte);
      logic [63:0] mask;
      logic [63:0] w;
      int unsigned n;
      int unsigned limit;
      mask = mode_wide ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
      if (kind == vzc_pkg::KIND_ENCODE) begin
         w = word & mask;
         if (mode_zigzag)
            w = ((w << 1) ^ ((mode_wide ? w[63] : w[31]) ? mask : 64'd0)) & mask;
         n = 0;
         while (w >= 64'(vzc_pkg::CONT_BIT) && n < vzc_pkg::MAX_CONT_BYTES) begin
            expect_result('{vzc_pkg::KIND_ENCODE, {1'b1, w[6:0]}, 1'b0, 64'd0});
            w = w >> 7;
            n++;
         end
         expect_result('{vzc_pkg::KIND_ENCODE, w[7:0], 1'b1, 64'd0});
      end else begin
         limit = mode_wide ? vzc_pkg::MAX_GROUPS_WIDE : vzc_pkg::MAX_GROUPS_NARROW;
         if (decode_groups < vzc_pkg::MAX_GROUPS_ALL)
            decode_acc = (decode_acc | ({57'd0, data_byte[6:0]} << (decode_groups * 7))) & mask;
         decode_groups++;
         if (!data_byte[7] || decode_groups >= limit) begin
            w = decode_acc & mask;
            if (mode_zigzag)
               w = ((w >> 1) ^ (w[0] ? mask : 64'd0)) & mask;
            expect_result('{vzc_pkg::KIND_DECODE, 8'd0, 1'b1, w});
            decode_acc = '0;
            decode_groups = 0;
         end
      end
   endtask

   // called at a falling edge; returns at a falling edge
   task automatic send_item(input vzc_pkg::kind_type kind, input logic [63:0] word,
                            input logic [7:0] data_byte);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {data_byte, word};
      do @(posedge clock); while (!req_tready);
      predict_codec(kind, word, data_byte);
      items_sent++;
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end else
         burst_left--;
   endtask

   task automatic encode_word(input logic [63:0] word);
      send_item(vzc_pkg::KIND_ENCODE, word, 8'($urandom));
   endtask

   task automatic decode_byte(input logic [7:0] data_byte);
      send_item(vzc_pkg::KIND_DECODE, {$urandom, $urandom}, data_byte);
   endtask

   // hold the sender until every expected result is out and the pipe is empty
   task automatic drain_results();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input vzc_pkg::reg_index_type index, input logic bit_value);
      drain_results();
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = $urandom;
      csr_pwdata[0] = bit_value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == vzc_pkg::REG_WIDE_MODE)
         mode_wide = bit_value;
      else
         mode_zigzag = bit_value;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_modes(input logic wide, input logic zigzag);
      csr_write(vzc_pkg::REG_WIDE_MODE, wide);
      csr_write(vzc_pkg::REG_SIGNED_MODE, zigzag);
   endtask

   function automatic logic [63:0] random_word();
      logic [63:0] full;
      full = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: random_word = 64'($urandom_range(0, 300));
         1, 2: random_word = full >> $urandom_range(0, 63);
         3: random_word = full;
         default:
            case ($urandom_range(0, 3))
               0: random_word = {64{1'b1}};
               1: random_word = 64'h8000_0000_0000_0000;
               2: random_word = {full[63:32], 32'h8000_0000};
               default: random_word = {full[63:32], 32'h7FFF_FFFF};
            endcase
      endcase
   endfunction

   // mostly well-formed varints with random groups; some broken or overlong
   task automatic send_varint_bytes();
      int unsigned groups;
      int unsigned limit;
      logic [7:0] data_byte;
      limit = mode_wide ? vzc_pkg::MAX_GROUPS_WIDE : vzc_pkg::MAX_GROUPS_NARROW;
      groups = ($urandom_range(0, 3) == 0) ? $urandom_range(1, limit + 2) : $urandom_range(1, 3);
      for (int unsigned i = 0; i < groups; i++) begin
         data_byte = 8'($urandom);
         data_byte[7] = (i + 1 < groups);
         if ($urandom_range(0, 9) == 0)
            data_byte[7] = ~data_byte[7];
         decode_byte(data_byte);
      end
   endtask

   task automatic test_encode_extremes();
      encode_word(64'd0);
      encode_word(64'd127);
      encode_word(64'd128);
      encode_word({64{1'b1}});
      encode_word(64'h8000_0000_0000_0000);
   endtask

   task automatic test_decode_basic();
      decode_byte(8'h96);
      decode_byte(8'h01);
      decode_byte(8'h7F);
      decode_byte(8'h00);
   endtask

   task automatic test_zigzag();
      set_modes(1'b1, 1'b1);
      encode_word(64'h8000_0000_0000_0000);
      encode_word({64{1'b1}});
      encode_word(64'h7FFF_FFFF_FFFF_FFFF);
      decode_byte(8'h01);
      csr_write(vzc_pkg::REG_WIDE_MODE, 1'b0);
      encode_word(64'hDEAD_BEEF_8000_0000);
   endtask

   // narrow words: upper input bits ignored, value forced out at five groups
   task automatic test_overlong_narrow();
      set_modes(1'b0, 1'b0);
      encode_word({64{1'b1}});
      repeat (5) decode_byte(8'hFF);
   endtask

   task automatic test_interleave();
      set_modes(1'b1, 1'b0);
      decode_byte(8'h80);
      encode_word(64'h0123_4567_89AB_CDEF);
      decode_byte(8'h05);
   endtask

   // four groups in wide mode, then narrow: the next byte hits the limit
   task automatic test_mode_change_mid_decode();
      set_modes(1'b1, 1'b0);
      repeat (4) decode_byte(8'h81);
      csr_write(vzc_pkg::REG_WIDE_MODE, 1'b0);
      decode_byte(8'hFF);
   endtask

   task automatic run_random_phase(input logic wide, input logic zigzag,
                                   input int unsigned count);
      int unsigned start;
      set_modes(wide, zigzag);
      start = items_sent;
      while (items_sent - start < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: encode_word(random_word());
            5, 6, 7, 8: send_varint_bytes();
            default: decode_byte(8'($urandom));
         endcase
      end
   endtask

   task automatic test_random();
      run_random_phase(1'b1, 1'b0, 60);
      run_random_phase(1'b0, 1'b1, 60);
      run_random_phase(1'b1, 1'b1, 60);
      run_random_phase(1'b0, 1'b0, 60);
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none actual kind %b byte %h last %b value %h",
                     $time, rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[71:8]);
            mismatch_count++;
         end else begin
            oldest = pending_results.pop_front();
            compare_field("out_kind", 64'(oldest.out_kind), 64'(rsp_tuser));
            compare_field("out_byte", 64'(oldest.out_byte), 64'(rsp_tdata[7:0]));
            compare_field("last", 64'(oldest.last), 64'(rsp_tlast));
            compare_field("decoded_value", oldest.value, rsp_tdata[71:8]);
         end
      end
   end

   // receiver: long free runs, short bursts and stalls
   always @(negedge clock) begin
      if (ready_phase_left == 0) begin
         case ($urandom_range(0, 5))
            0: begin
               rsp_tready = 1'b1;
               ready_phase_left = $urandom_range(30, 80);
            end
            1, 2: begin
               rsp_tready = 1'b0;
               ready_phase_left = $urandom_range(1, 12);
            end
            default: begin
               rsp_tready = 1'b1;
               ready_phase_left = $urandom_range(1, 6);
            end
         endcase
      end else
         ready_phase_left--;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         idle_cycles = 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else
         idle_cycles++;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_encode_extremes();
      test_decode_basic();
      test_zigzag();
      test_overlong_narrow();
      test_interleave();
      test_mode_change_mid_decode();
      test_random();
      drain_results();
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
